>>> rtl/core/assert_macros.svh
// Assertion macros for the substring search core.
// Included by the top level; a build with SYNTH defined compiles them to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Clocked check, skipped while reset is asserted.
`define ASSERT_CLKD(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds through reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_CLKD(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

>>> rtl/core/ssf_pkg.sv
// Shared constants, register codes, config struct and byte helpers
// for the substring search core. No dependencies.
package ssf_pkg;

    localparam int PATTERN_MAX_DEF   = 16;
    localparam int POSITION_BITS_DEF = 16;

    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 64;
    localparam int LEN_W       = 5;
    localparam int PAT_BYTES   = 16;

    // Register indexes on the config port.
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LOW    = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_HIGH   = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LENGTH = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_CASE_SENSITIVE = 4'd3;

    localparam logic [7:0] FOLD_BIT = 8'h20;

    typedef struct packed {
        logic [PAT_BYTES*8-1:0] pattern;        // byte 0 in bits 7:0
        logic [LEN_W-1:0]       length;
        logic                   case_sensitive;
    } cfg_t;

    function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic cs);
        return cs ? b : (b | FOLD_BIT);
    endfunction

    // Pattern bytes past the sixteenth read as zero.
    function automatic logic [7:0] pattern_byte(input logic [PAT_BYTES*8-1:0] pat,
                                                input logic [LEN_W-1:0] idx);
        if (idx[LEN_W-1])
            return 8'h00;
        return pat[idx[LEN_W-2:0]*8 +: 8];
    endfunction

endpackage

>>> rtl/core/ssf_cfg.sv
// Configuration register file: pattern, length and case mode.
// Depends on ssf_pkg.
module ssf_cfg
    import ssf_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                   cfg
);

    logic [CFG_DATA_W-1:0] pattern_low_reg;
    logic [CFG_DATA_W-1:0] pattern_high_reg;
    logic [LEN_W-1:0]      pattern_length_reg;
    logic                  case_sensitive_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
            pattern_length_reg <= '0;
            case_sensitive_reg <= 1'b1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_PATTERN_LOW:    pattern_low_reg    <= cfg_data;
                CFG_PATTERN_HIGH:   pattern_high_reg   <= cfg_data;
                CFG_PATTERN_LENGTH: pattern_length_reg <= cfg_data[LEN_W-1:0];
                CFG_CASE_SENSITIVE: case_sensitive_reg <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    assign cfg.pattern        = {pattern_high_reg, pattern_low_reg};
    assign cfg.length         = pattern_length_reg;
    assign cfg.case_sensitive = case_sensitive_reg;

endmodule

>>> rtl/core/ssf_window.sv
// Text window shift line, saturating byte counter and reported flag.
// Depends on ssf_pkg.
module ssf_window
    import ssf_pkg::*;
#(
    parameter int PATTERN_MAX   = PATTERN_MAX_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  logic [7:0]                   text_byte,
    input  logic                         last,
    input  logic                         hit,
    output logic [PATTERN_MAX-1:0][7:0]  window_next,
    output logic [POSITION_BITS:0]       count_next,
    output logic                         reported
);

    localparam int CountW = POSITION_BITS + 1;
    // POSITION_MAX + PATTERN_MAX keeps offsets exact under saturation
    localparam logic [CountW-1:0] CountMax =
        {1'b0, {POSITION_BITS{1'b1}}} + CountW'(PATTERN_MAX);

    logic [PATTERN_MAX-1:0][7:0] window_reg;   // newest byte at index 0
    logic [CountW-1:0]           count_reg;
    logic                        reported_reg;

    assign window_next = {window_reg[PATTERN_MAX-2:0], text_byte};
    assign count_next  = (count_reg < CountMax) ? count_reg + 1'b1 : count_reg;
    assign reported    = reported_reg;

    // stale bytes are masked by the count, so the line needs no reset
    always_ff @(posedge clk)
    begin
        if (accept && !last && !reported_reg)
            window_reg <= window_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            reported_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (last)
            begin
                count_reg    <= '0;
                reported_reg <= 1'b0;
            end
            else if (!reported_reg)
            begin
                count_reg    <= count_next;
                reported_reg <= hit;
            end
        end
    end

endmodule

>>> rtl/core/ssf_match.sv
// Parallel window compare against the pattern and match offset.
// Depends on ssf_pkg.
module ssf_match
    import ssf_pkg::*;
#(
    parameter int PATTERN_MAX   = PATTERN_MAX_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF
)
(
    input  logic [PATTERN_MAX-1:0][7:0] window,
    input  logic [POSITION_BITS:0]      count,
    input  cfg_t                        cfg,
    output logic                        hit,
    output logic [POSITION_BITS-1:0]    start
);

    localparam int CountW = POSITION_BITS + 1;

    logic [PATTERN_MAX-1:0] lane_ok;
    logic                   len_ok;
    logic                   count_ok;
    logic [CountW-1:0]      diff;

    // lane i holds the byte i places back; it pairs with pattern byte len-1-i
    for (genvar i = 0; i < PATTERN_MAX; i++)
    begin : g_lane
        logic [LEN_W-1:0] pidx;
        logic             active;
        assign pidx   = cfg.length - LEN_W'(1) - LEN_W'(i);
        assign active = {1'b0, cfg.length} > 6'(i);
        assign lane_ok[i] = !active ||
            (fold_byte(window[i], cfg.case_sensitive) ==
             fold_byte(pattern_byte(cfg.pattern, pidx), cfg.case_sensitive));
    end

    assign len_ok   = (cfg.length != '0) && ({1'b0, cfg.length} <= 6'(PATTERN_MAX));
    assign count_ok = count >= CountW'(cfg.length);
    assign hit      = len_ok && count_ok && (&lane_ok);

    assign diff  = count - CountW'(cfg.length);
    assign start = diff[CountW-1] ? {POSITION_BITS{1'b1}} : diff[POSITION_BITS-1:0];

endmodule

>>> rtl/core/substring_search_case_fold_unit.sv
// Streaming first-occurrence substring search with optional case folding.
// A result is registered: it is valid in the cycle after the byte that causes it is accepted.
// Throughput: one text byte per cycle while results drain; the window compare is one register-to-register pass.
// Reset (async, active low): pattern and length cleared, case_sensitive set,
// byte counter and reported flag cleared, output register empty.
module substring_search_case_fold_unit
    import ssf_pkg::*;
#(
    parameter int PATTERN_MAX   = PATTERN_MAX_DEF,    // window depth, 2..32
    parameter int POSITION_BITS = POSITION_BITS_DEF   // offset width, 8..32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // config write channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // text input
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // [7:0] text_byte
    input  logic                   s_tlast,   // last byte of the string
    // results
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [((POSITION_BITS+7)/8)*8-1:0] m_tdata,  // position from bit 0, zero fill
    output logic [0:0]             m_tuser    // [0] found
);

    localparam int OutTdataW = ((POSITION_BITS + 7) / 8) * 8;

    `include "assert_macros.svh"

    cfg_t                        cfg;
    logic                        accept;
    logic                        emit;
    logic                        hit;
    logic                        reported;
    logic [PATTERN_MAX-1:0][7:0] window_next;
    logic [POSITION_BITS:0]      count_next;
    logic [POSITION_BITS-1:0]    start;

    logic                        out_valid_reg;
    logic                        out_found_reg;
    logic [POSITION_BITS-1:0]    out_position_reg;

    ssf_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ssf_window #(
        .PATTERN_MAX   (PATTERN_MAX),
        .POSITION_BITS (POSITION_BITS)
    ) u_window (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .text_byte   (s_tdata),
        .last        (s_tlast),
        .hit         (hit),
        .window_next (window_next),
        .count_next  (count_next),
        .reported    (reported)
    );

    // compares the window as it stands after taking the current byte
    ssf_match #(
        .PATTERN_MAX   (PATTERN_MAX),
        .POSITION_BITS (POSITION_BITS)
    ) u_match (
        .window (window_next),
        .count  (count_next),
        .cfg    (cfg),
        .hit    (hit),
        .start  (start)
    );

    // Take a new word whenever the output register is empty or draining.
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // One result per string: at the first hit, or at the last byte if none.
    // Bytes after a hit are dropped until the last flag.
    assign emit = !reported && (hit || s_tlast);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept && emit)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            out_found_reg    <= hit;
            out_position_reg <= hit ? start : '0;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = OutTdataW'(out_position_reg);
    assign m_tuser[0] = out_found_reg;

    // Emitted result lands in the output register with the matching flag.
    `ASSERT_CLKD(a_emit_loads, clk, rst_n,
        (accept && emit) |=> (out_valid_reg && (out_found_reg == $past(hit))),
        "result not loaded after emit")

    // A not-found result always carries a zero offset.
    `ASSERT_CLKD(a_miss_zero_pos, clk, rst_n,
        (out_valid_reg && !out_found_reg) |-> (out_position_reg == '0),
        "not-found result with nonzero position")

    // Last byte ends the string: reported flag is clear on the next cycle.
    `ASSERT_CLKD(a_last_clears, clk, rst_n,
        (accept && s_tlast) |=> !reported,
        "reported flag survived end of string")

    // Once reported, no further result for the same string.
    `ASSERT_CLKD(a_single_result, clk, rst_n,
        (accept && reported) |-> !emit,
        "second result for one string")

endmodule

>>> tb/sv/substring_search_case_fold_unit_tb.sv
// Self-checking bench for substring_search_case_fold_unit: a scoreboard class that tracks the
// search per string, plus directed, long-string and random stimulus on the byte stream.
// Depends on ssf_pkg and the unit's RTL only.
import ssf_pkg::*;

typedef struct packed {
    logic        found;
    logic [15:0] position;
} search_hit_t;

class hit_tracker;
    localparam int WINDOW    = 16;
    localparam int POS_MAX   = 65535;
    localparam int COUNT_SAT = POS_MAX + WINDOW;

    // register shadow
    logic [63:0]      pat_low;
    logic [63:0]      pat_high;
    logic [LEN_W-1:0] pat_len;
    logic             exact;

    // per-string search state
    logic [7:0]  window_q[WINDOW];   // newest byte at 0
    int          seen;
    bit          reported;
    search_hit_t pending_hits[$];
    int          failures;

    function new();
        pat_low  = '0;
        pat_high = '0;
        pat_len  = '0;
        exact    = 1'b1;
        failures = 0;
        restart();
    endfunction

    function void restart();
        foreach (window_q[i]) window_q[i] = 8'h00;
        seen     = 0;
        reported = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        case (idx)
            CFG_PATTERN_LOW:    pat_low  = value;
            CFG_PATTERN_HIGH:   pat_high = value;
            CFG_PATTERN_LENGTH: pat_len  = value[LEN_W-1:0];
            CFG_CASE_SENSITIVE: exact    = value[0];
            default: ;
        endcase
    endfunction

    function logic [7:0] folded(logic [7:0] b);
        return exact ? b : (b | FOLD_BIT);
    endfunction

    function logic [7:0] pattern_at(int k);
        if (k < 8)
            return pat_low[k*8 +: 8];
        return pat_high[(k-8)*8 +: 8];
    endfunction

    // Window ends at the newest byte; pattern compared back to front.
    function bit window_hit();
        int len;
        len = pat_len;
        if (len == 0 || len > WINDOW || seen < len)
            return 0;
        for (int i = 0; i < len; i++)
            if (folded(window_q[i]) != folded(pattern_at(len - 1 - i)))
                return 0;
        return 1;
    endfunction

    function void note_text_byte(logic [7:0] b, bit fin);
        search_hit_t hit;
        int start;
        if (!reported) begin
            for (int i = WINDOW - 1; i > 0; i--)
                window_q[i] = window_q[i-1];
            window_q[0] = b;
            if (seen < COUNT_SAT)
                seen++;
            if (window_hit()) begin
                start = seen - int'(pat_len);
                hit.found    = 1'b1;
                hit.position = (start > POS_MAX) ? 16'hFFFF : 16'(start);
                pending_hits.push_back(hit);
                reported = 1;
            end
        end
        if (fin) begin
            if (!reported) begin
                hit.found    = 1'b0;
                hit.position = 16'h0000;
                pending_hits.push_back(hit);
            end
            restart();
        end
    endfunction

    function void report(string what);
        failures++;
        if (failures <= 10)
            $display("[%0t] ERROR %s", $time, what);
    endfunction

    function void check_hit(logic found, logic [15:0] position);
        search_hit_t want;
        if (pending_hits.size() == 0) begin
            report($sformatf("unexpected result found=%0d position=%0d", found, position));
            return;
        end
        want = pending_hits.pop_front();
        if (found !== want.found)
            report($sformatf("found: expected %0d, got %0d", want.found, found));
        if (position !== want.position)
            report($sformatf("position: expected %0d, got %0d", want.position, position));
    endfunction

    function int outstanding();
        return pending_hits.size();
    endfunction

    function void flush_leftovers();
        while (pending_hits.size() != 0) begin
            void'(pending_hits.pop_front());
            report("expected result never arrived");
        end
    endfunction
endclass

module substring_search_case_fold_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [7:0] text_q_t[$];

    localparam int                     CYCLE_LIMIT  = 1_000_000;
    // one result register: a byte's effect is settled well within this
    localparam int                     SETTLE       = 4;
    // index past the register list; a write there must change nothing
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE    = 4'd9;
    localparam int                     PHASE_WORDS  = 88;
    localparam int                     PHASES       = 8;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata   = 8'h00;   // [7:0] text_byte
    logic                   s_tlast   = 1'b0;    // last byte of the string
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [15:0]            m_tdata;             // [15:0] position
    logic [0:0]             m_tuser;             // [0] found

    hit_tracker sb = new();

    // Current setting, kept here to steer the random text toward matches.
    logic [127:0] cur_pat = '0;
    int           cur_len = 0;
    bit           cur_exact = 1'b1;
    // Set for stretches where neither side idles.
    bit           no_gaps = 1'b0;
    int           cycles = 0;

    substring_search_case_fold_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Result side: random stall before each word, then ready until one is taken.
    initial
    begin : result_sink
        int stall;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = no_gaps ? 0 : $urandom_range(0, 10);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            sb.check_hit(m_tuser[0], m_tdata);
        end
    end

    // One text word. Valid stays high when the next word follows with no gap,
    // so it is only lowered when a gap is drawn or the stream pauses.
    task automatic send_text_byte(input logic [7:0] b, input bit fin);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= fin;
        do @(posedge clk); while (!s_tready);
        sb.note_text_byte(b, fin);
    endtask

    task automatic send_text(input text_q_t s);
        foreach (s[k]) send_text_byte(s[k], k == s.size() - 1);
    endtask

    task automatic send_ascii(input string s);
        text_q_t q;
        for (int k = 0; k < s.len(); k++) q.push_back(s[k]);
        send_text(q);
    endtask

    // Stop the stream and let every expected result come out.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Leaves cfg_valid high; the caller lowers it after the last write.
    task automatic cfg_put(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, d);
    endtask

    // Only called with the block idle (after reset or after drain).
    task automatic set_pattern(input logic [127:0] pat, input int len, input bit exact);
        cfg_put(CFG_PATTERN_LOW, pat[63:0]);
        cfg_put(CFG_PATTERN_HIGH, pat[127:64]);
        cfg_put(CFG_PATTERN_LENGTH, CFG_DATA_W'(len));
        cfg_put(CFG_CASE_SENSITIVE, CFG_DATA_W'(exact));
        cfg_valid <= 1'b0;
        cur_pat   = pat;
        cur_len   = len;
        cur_exact = exact;
    endtask

    // Mostly letters of either case, some raw bytes and the punctuation that folding disturbs.
    function automatic logic [7:0] random_pattern_byte();
        int r;
        logic [7:0] punct[4] = '{8'h40, 8'h60, 8'h5B, 8'h7B};
        r = $urandom_range(0, 9);
        if (r < 7)
            return 8'h41 + 8'($urandom_range(0, 25)) | ($urandom_range(0, 1) ? FOLD_BIT : 8'h00);
        if (r < 9)
            return 8'($urandom_range(0, 255));
        return punct[$urandom_range(0, 3)];
    endfunction

    // Half the text comes from the pattern's own bytes so partial matches are common.
    function automatic logic [7:0] random_text_byte();
        logic [7:0] b;
        b = 8'($urandom_range(1, 255));
        if (cur_len > 0 && $urandom_range(0, 1))
        begin
            b = cur_pat[$urandom_range(0, cur_len - 1)*8 +: 8];
            if ($urandom_range(0, 3) == 0)
                b ^= FOLD_BIT;
            if (b == 8'h00)
                b = 8'($urandom_range(1, 255));
        end
        return b;
    endfunction

    // Random string, optionally with a full copy of the pattern planted in it.
    task automatic send_random_string(input int n, input bit plant);
        text_q_t s;
        int at;
        logic [7:0] b;
        for (int k = 0; k < n; k++) s.push_back(random_text_byte());
        if (plant && cur_len > 0 && cur_len <= n)
        begin
            at = $urandom_range(0, n - cur_len);
            for (int k = 0; k < cur_len; k++)
            begin
                b = cur_pat[k*8 +: 8];
                if (!cur_exact && $urandom_range(0, 1))
                    b ^= FOLD_BIT;
                // text bytes are never zero; a space still matches a zero under folding
                if (b == 8'h00)
                    b = FOLD_BIT;
                s[at + k] = b;
            end
        end
        send_text(s);
    endtask

    // String of n filler bytes, then an optional tail, sent with no idling when no_gaps is set.
    task automatic send_long_string(input int n, input string tail);
        text_q_t s;
        for (int k = 0; k < n; k++) s.push_back("a");
        for (int k = 0; k < tail.len(); k++) s.push_back(tail[k]);
        send_text(s);
    endtask

    initial
    begin : stimulus
        text_q_t ones;
        logic [127:0] pat;
        int len;
        int sent;
        int n;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed ----
        // Reset setting has an empty pattern: never matches.
        send_ascii("ab");
        drain();

        // Exact compare, two bytes "aB"; the spare index write must not disturb anything.
        cfg_put(CFG_SPARE, '1);
        set_pattern(128'h4261, 2, 1'b1);
        send_ascii("xaB");
        send_ascii("ab");
        drain();

        // Folded compare; bytes after the match are ignored; too-short text.
        set_pattern(128'h4261, 2, 1'b0);
        send_ascii("zAbq");
        send_ascii("a");
        drain();

        // Folding maps '@' onto '`'; match lands on the last byte.
        set_pattern(128'h60, 1, 1'b0);
        send_ascii("@");
        drain();

        // Full-width all-ones pattern, top text byte extreme, then the low extreme.
        set_pattern('1, 16, 1'b1);
        for (int k = 0; k < 16; k++) ones.push_back(8'hFF);
        send_text(ones);
        ones = {};
        ones.push_back(8'h01);
        send_text(ones);
        drain();

        // ---- long strings: offset near and past the 16-bit limit ----
        no_gaps = 1'b1;
        set_pattern(128'h7A7978, 3, 1'b1);
        send_long_string(65534, "xyz");
        send_long_string(65600, "xyz");
        send_long_string(65600, "");
        drain();
        no_gaps = 1'b0;

        // ---- random phases, each with its own setting ----
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:       begin pat = '1; len = 16; end
                1:       begin pat = '0; len = 16; end
                2:       begin pat = '0; len = 1;  end
                3:       begin pat = '0; len = 0;  end
                default: begin pat = '0; len = $urandom_range(1, 16); end
            endcase
            if (ph >= 2)
                for (int k = 0; k < 16; k++) pat[k*8 +: 8] = random_pattern_byte();
            set_pattern(pat, len, ph == 0 ? 1'b1 : ph == 1 ? 1'b0 : 1'($urandom_range(0, 1)));

            sent = 0;
            while (sent < PHASE_WORDS)
            begin
                if ($urandom_range(0, 7) == 0)
                    n = $urandom_range(20, 60);
                else
                    n = $urandom_range(1, cur_len + 12);
                no_gaps = ($urandom_range(0, 4) == 0);
                send_random_string(n, $urandom_range(0, 3) != 0);
                sent += n;
                // now and then hold the stream until the results catch up
                if ($urandom_range(0, 24) == 0)
                    drain();
            end
            no_gaps = 1'b0;
            drain();
        end

        // ---- wrap up ----
        drain();
        repeat (20) @(posedge clk);
        sb.flush_leftovers();
        if (sb.failures == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

>>> files.f
+incdir+rtl/core
rtl/core/ssf_pkg.sv
rtl/core/ssf_cfg.sv
rtl/core/ssf_window.sv
rtl/core/ssf_match.sv
rtl/core/substring_search_case_fold_unit.sv
tb/sv/substring_search_case_fold_unit_tb.sv
